// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants for the first-fit block allocator: default sizes,
// request codes and status codes.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // Default configuration of the allocator.
    localparam int DEF_MAX_BLOCKS  = 1024;
    localparam int DEF_ALIGN_BYTES = 64;
    localparam int DEF_OFFSET_BITS = 32;

    // Width of the size, start and result ports.
    localparam int PORT_BITS = 32;

    // A rounded request can reach one bit beyond the size port.
    localparam int RND_BITS = PORT_BITS + 1;

    // Request codes.
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_RESIZE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;

endpackage

// ===== rtl/ffba_table.sv =====
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port and one read port with registered
// read data. Each word packs busy flag, size and start of one block.
// ----------------------------------------------------------------------------
module ffba_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 65
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ffba_round.sv =====
// ----------------------------------------------------------------------------
// ffba_round
// Rounds a request size up to the alignment, never below one alignment
// unit. The quotient comes from a reciprocal multiplication, then one
// compare-subtract step fixes it; the result is ready when done pulses.
// ----------------------------------------------------------------------------
module ffba_round
    import ffba_pkg::*;
#(
    parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic [PORT_BITS-1:0] size,
    output logic                 done,
    output logic [RND_BITS-1:0]  rounded
);

    localparam int PW = 2 * RND_BITS + 1;
    localparam logic [PORT_BITS-1:0] ALIGN_P = PORT_BITS'(ALIGN_BYTES);
    localparam logic [RND_BITS-1:0]  ALIGN_T = RND_BITS'(ALIGN_BYTES);
    // floor(2^RND_BITS / ALIGN_BYTES): the estimate is low by at most one.
    localparam logic [RND_BITS:0]    RECIP   =
        (RND_BITS + 1)'((64'd1 << RND_BITS) / 64'(ALIGN_BYTES));

    // Sequencer phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_QUOT = 2'd1;
    localparam logic [1:0] PH_PROD = 2'd2;
    localparam logic [1:0] PH_FIX  = 2'd3;

    logic [1:0]           ph_reg,   ph_next;
    logic [RND_BITS-1:0]  t_reg,    t_next;
    logic [RND_BITS-1:0]  q_reg,    q_next;
    logic [RND_BITS-1:0]  p_reg,    p_next;
    logic                 done_reg, done_next;
    logic [PORT_BITS-1:0] clamp;
    logic [PW-1:0]        prod;
    logic [RND_BITS-1:0]  rem;

    // Clamp to one alignment unit; the sum below adds the alignment less one.
    assign clamp = (size < ALIGN_P) ? ALIGN_P : size;
    assign prod  = PW'(t_reg) * PW'(RECIP);
    assign rem   = t_reg - p_reg;

    always_comb
    begin
        ph_next   = ph_reg;
        t_next    = t_reg;
        q_next    = q_reg;
        p_next    = p_reg;
        done_next = 1'b0;
        unique case (ph_reg)
            PH_IDLE:
            begin
                if (go)
                begin
                    t_next  = {1'b0, clamp} + RND_BITS'(ALIGN_BYTES - 1);
                    ph_next = PH_QUOT;
                end
            end
            PH_QUOT:
            begin
                // Quotient estimate by reciprocal multiplication.
                q_next  = prod[RND_BITS +: RND_BITS];
                ph_next = PH_PROD;
            end
            PH_PROD:
            begin
                p_next  = q_reg * ALIGN_T;
                ph_next = PH_FIX;
            end
            PH_FIX:
            begin
                done_next = 1'b1;
                ph_next   = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        q_reg <= q_next;
        p_reg <= p_next;
    end

    // A low estimate leaves one more alignment unit to add back.
    assign done    = done_reg;
    assign rounded = (rem >= ALIGN_T) ? p_reg + ALIGN_T : p_reg;

endmodule

// ===== rtl/first_fit_block_allocator_core.sv =====
// Sequence: rounding first, then a read and an evaluate state per table
// entry scanned by lookup and first-fit search, plus a read and a write
// state per entry shifted when a merge drops an entry.
// Throughput: one request at a time; busy stays high until done pulses.
// The table memory with one registered read per cycle sets the pace.
// Reset (rst_n, asynchronous): empty table, pool and free tail zero.
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit allocator over an ordered block table kept in memory. A small
// sequencer drives lookup, search, append, release and entry shift passes.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
    parameter int ALIGN_BYTES = DEF_ALIGN_BYTES,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pool_size_we,
    input  logic [PORT_BITS-1:0] pool_size,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           op,
    input  logic [PORT_BITS-1:0] size_bytes,
    input  logic [PORT_BITS-1:0] block_start,
    input  logic                 has_block,
    output logic                 done,
    output logic [2:0]           status,
    output logic [PORT_BITS-1:0] result_start,
    output logic                 result_valid,
    output logic                 moved,
    output logic [PORT_BITS-1:0] old_start,
    output logic [PORT_BITS-1:0] copy_bytes,
    output logic [PORT_BITS-1:0] bytes_remaining
);

    localparam int OB = OFFSET_BITS;
    localparam int VW = ((OB > PORT_BITS) ? OB : PORT_BITS) + 1;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int DW = 2 * OB + 1;
    localparam logic [VW-1:0] POOL_LIM = VW'((64'd1 << OB) - 64'd1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_BLOCKS);

    // Sequencer states.
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_RND    = 5'd1;
    localparam logic [4:0] S_A_RD   = 5'd2;
    localparam logic [4:0] S_A_EV   = 5'd3;
    localparam logic [4:0] S_L_RD   = 5'd4;
    localparam logic [4:0] S_L_EV   = 5'd5;
    localparam logic [4:0] S_RS_DEC = 5'd6;
    localparam logic [4:0] S_R_INIT = 5'd7;
    localparam logic [4:0] S_R_CHK  = 5'd8;
    localparam logic [4:0] S_R_PREV = 5'd9;
    localparam logic [4:0] S_R_NEXT = 5'd10;
    localparam logic [4:0] S_R_LEFT = 5'd11;
    localparam logic [4:0] S_D_RD   = 5'd12;
    localparam logic [4:0] S_D_WR   = 5'd13;
    localparam logic [4:0] S_FINISH = 5'd14;

    logic [4:0]    state_reg,  state_next;
    logic [1:0]    op_reg,     op_next;
    logic          move_reg,   move_next;
    logic [31:0]   bstart_reg, bstart_next;
    logic [VW-1:0] r_reg,      r_next;
    logic [CW-1:0] k_reg,      k_next;
    logic [IW-1:0] i_reg,      i_next;
    logic [OB-1:0] istart_reg, istart_next;
    logic [OB-1:0] isz_reg,    isz_next;
    logic          ibusy_reg,  ibusy_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [OB-1:0] tail_reg,   tail_next;
    logic [OB-1:0] pool_reg,   pool_next;
    logic [2:0]    st_reg,     st_next;
    logic [OB-1:0] res_reg,    res_next;
    logic          valid_reg,  valid_next;
    logic          moved_reg,  moved_next;
    logic [OB-1:0] olds_reg,   olds_next;
    logic [OB-1:0] copy_reg,   copy_next;

    logic          tbl_we;
    logic [IW-1:0] tbl_waddr;
    logic [DW-1:0] tbl_wdata;
    logic [IW-1:0] tbl_raddr;
    logic [DW-1:0] tbl_rdata;
    logic [OB-1:0] rd_start;
    logic [OB-1:0] rd_size;
    logic          rd_busy;

    logic                rnd_go;
    logic                rnd_done;
    logic [RND_BITS-1:0] rnd_r;
    logic [1:0]          op_eff;
    logic                accept;
    logic [VW-1:0]       pool_in;
    logic [CW-1:0]       i_plus1;
    logic [VW-1:0]       isz_x;
    logic [VW-1:0]       tail_x;
    logic [VW-1:0]       diff;
    logic [OB-1:0]       new_start;

    ffba_table #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IW),
        .DW    (DW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    ffba_round #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_round (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (rnd_go),
        .size    (size_bytes),
        .done    (rnd_done),
        .rounded (rnd_r)
    );

    assign rd_start  = tbl_rdata[OB-1:0];
    assign rd_size   = tbl_rdata[2*OB-1:OB];
    assign rd_busy   = tbl_rdata[2*OB];
    assign accept    = start && (state_reg == S_IDLE);
    assign pool_in   = VW'(pool_size);
    assign i_plus1   = CW'(i_reg) + 1'b1;
    assign isz_x     = VW'(isz_reg);
    assign tail_x    = VW'(tail_reg);
    assign diff      = r_reg - isz_x;
    assign new_start = pool_reg - tail_reg;

    // Fold resize-to-zero into free and resize-of-null into allocate.
    always_comb
    begin
        op_eff = op;
        if (op == OP_RESIZE && has_block && size_bytes == '0)
        begin
            op_eff = OP_FREE;
        end
        else if (op == OP_RESIZE && !has_block)
        begin
            op_eff = OP_ALLOC;
        end
    end

    // Sequencer: next state, table access and register updates.
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        move_next   = move_reg;
        bstart_next = bstart_reg;
        r_next      = r_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        istart_next = istart_reg;
        isz_next    = isz_reg;
        ibusy_next  = ibusy_reg;
        count_next  = count_reg;
        tail_next   = tail_reg;
        pool_next   = pool_reg;
        st_next     = st_reg;
        res_next    = res_reg;
        valid_next  = valid_reg;
        moved_next  = moved_reg;
        olds_next   = olds_reg;
        copy_next   = copy_reg;
        tbl_we      = 1'b0;
        tbl_waddr   = i_reg;
        tbl_wdata   = {ibusy_reg, isz_reg, istart_reg};
        tbl_raddr   = k_reg[IW-1:0];
        rnd_go      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // A pool write empties the table.
                if (pool_size_we)
                begin
                    pool_next  = (pool_in > POOL_LIM) ? OB'(POOL_LIM) : OB'(pool_in);
                    tail_next  = (pool_in > POOL_LIM) ? OB'(POOL_LIM) : OB'(pool_in);
                    count_next = '0;
                end
                if (accept)
                begin
                    op_next     = op_eff;
                    bstart_next = block_start;
                    move_next   = 1'b0;
                    k_next      = '0;
                    st_next     = ST_OK;
                    res_next    = '0;
                    valid_next  = 1'b0;
                    moved_next  = 1'b0;
                    olds_next   = '0;
                    copy_next   = '0;
                    state_next  = S_FINISH;
                    case (op_eff)
                        OP_ALLOC:
                        begin
                            if (size_bytes == '0)
                            begin
                                st_next = ST_ZERO;
                            end
                            else
                            begin
                                rnd_go     = 1'b1;
                                state_next = S_RND;
                            end
                        end
                        OP_FREE:
                        begin
                            if (has_block)
                            begin
                                state_next = S_L_RD;
                            end
                        end
                        OP_RESIZE:
                        begin
                            rnd_go     = 1'b1;
                            state_next = S_RND;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_RND:
            begin
                if (rnd_done)
                begin
                    r_next     = VW'(rnd_r);
                    state_next = (op_reg == OP_ALLOC) ? S_A_RD : S_L_RD;
                end
            end

            // First-fit search over the table, else append at the tail.
            S_A_RD:
            begin
                if (k_reg == count_reg)
                begin
                    state_next = S_FINISH;
                    if (r_reg > tail_x)
                    begin
                        st_next = ST_EXHAUSTED;
                    end
                    else if (count_reg >= CNT_MAX)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        tbl_we     = 1'b1;
                        tbl_waddr  = count_reg[IW-1:0];
                        tbl_wdata  = {1'b1, r_reg[OB-1:0], new_start};
                        count_next = count_reg + 1'b1;
                        tail_next  = tail_reg - r_reg[OB-1:0];
                        res_next   = new_start;
                        valid_next = 1'b1;
                        if (move_reg)
                        begin
                            olds_next  = istart_reg;
                            copy_next  = isz_reg;
                            moved_next = 1'b1;
                            state_next = S_R_INIT;
                        end
                    end
                end
                else
                begin
                    state_next = S_A_EV;
                end
            end

            S_A_EV:
            begin
                if (!rd_busy && VW'(rd_size) >= r_reg)
                begin
                    tbl_we     = 1'b1;
                    tbl_waddr  = k_reg[IW-1:0];
                    tbl_wdata  = {1'b1, rd_size, rd_start};
                    res_next   = rd_start;
                    valid_next = 1'b1;
                    state_next = S_FINISH;
                    if (move_reg)
                    begin
                        olds_next  = istart_reg;
                        copy_next  = isz_reg;
                        moved_next = 1'b1;
                        state_next = S_R_INIT;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_A_RD;
                end
            end

            // Lookup of a block by its start.
            S_L_RD:
            begin
                if (k_reg == count_reg)
                begin
                    st_next    = ST_NOTFOUND;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_L_EV;
                end
            end

            S_L_EV:
            begin
                if (VW'(rd_start) == VW'(bstart_reg))
                begin
                    i_next      = k_reg[IW-1:0];
                    istart_next = rd_start;
                    isz_next    = rd_size;
                    ibusy_next  = rd_busy;
                    state_next  = (op_reg == OP_FREE) ? S_R_INIT : S_RS_DEC;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_L_RD;
                end
            end

            // Resize decision on the located block.
            S_RS_DEC:
            begin
                state_next = S_FINISH;
                if (i_plus1 == count_reg)
                begin
                    if (r_reg > isz_x && diff > tail_x)
                    begin
                        st_next = ST_EXHAUSTED;
                    end
                    else
                    begin
                        tbl_we     = 1'b1;
                        tbl_wdata  = {ibusy_reg, r_reg[OB-1:0], istart_reg};
                        tail_next  = tail_reg - diff[OB-1:0];
                        res_next   = istart_reg;
                        valid_next = 1'b1;
                    end
                end
                else if (r_reg > isz_x)
                begin
                    move_next  = 1'b1;
                    k_next     = '0;
                    state_next = S_A_RD;
                end
                else
                begin
                    res_next   = istart_reg;
                    valid_next = 1'b1;
                end
            end

            // Release: mark free, then pop or merge.
            S_R_INIT:
            begin
                tbl_we     = 1'b1;
                tbl_wdata  = {1'b0, isz_reg, istart_reg};
                state_next = S_R_CHK;
            end

            S_R_CHK:
            begin
                if (i_plus1 == count_reg)
                begin
                    tail_next  = tail_reg + isz_reg;
                    count_next = count_reg - 1'b1;
                    tbl_raddr  = i_reg - 1'b1;
                    state_next = (i_reg != '0) ? S_R_PREV : S_FINISH;
                end
                else
                begin
                    tbl_raddr  = i_reg + 1'b1;
                    state_next = S_R_NEXT;
                end
            end

            S_R_PREV:
            begin
                if (!rd_busy)
                begin
                    i_next     = i_reg - 1'b1;
                    isz_next   = rd_size;
                    state_next = S_R_CHK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_R_NEXT:
            begin
                if (!rd_busy)
                begin
                    tbl_we     = 1'b1;
                    tbl_wdata  = {1'b0, isz_reg + rd_size, istart_reg};
                    k_next     = i_plus1;
                    state_next = S_D_RD;
                end
                else if (i_reg != '0)
                begin
                    tbl_raddr  = i_reg - 1'b1;
                    state_next = S_R_LEFT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_R_LEFT:
            begin
                if (!rd_busy)
                begin
                    tbl_we     = 1'b1;
                    tbl_waddr  = i_reg - 1'b1;
                    tbl_wdata  = {1'b0, rd_size + isz_reg, rd_start};
                    k_next     = CW'(i_reg);
                    state_next = S_D_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            // Drop an entry by shifting the ones above it down.
            S_D_RD:
            begin
                if (k_reg + 1'b1 < count_reg)
                begin
                    tbl_raddr  = k_reg[IW-1:0] + 1'b1;
                    state_next = S_D_WR;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_FINISH;
                end
            end

            S_D_WR:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = k_reg[IW-1:0];
                tbl_wdata  = tbl_rdata;
                k_next     = k_reg + 1'b1;
                state_next = S_D_RD;
            end

            S_FINISH:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            tail_reg  <= '0;
            pool_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            tail_reg  <= tail_next;
            pool_reg  <= pool_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        move_reg   <= move_next;
        bstart_reg <= bstart_next;
        r_reg      <= r_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        istart_reg <= istart_next;
        isz_reg    <= isz_next;
        ibusy_reg  <= ibusy_next;
        st_reg     <= st_next;
        res_reg    <= res_next;
        valid_reg  <= valid_next;
        moved_reg  <= moved_next;
        olds_reg   <= olds_next;
        copy_reg   <= copy_next;
    end

    // Result transfer.
    assign busy            = (state_reg != S_IDLE);
    assign done            = (state_reg == S_FINISH);
    assign status          = st_reg;
    assign result_start    = VW'(res_reg) >> 0 == '0 ? '0 : PORT_BITS'(VW'(res_reg));
    assign result_valid    = valid_reg;
    assign moved           = moved_reg;
    assign old_start       = PORT_BITS'(VW'(olds_reg));
    assign copy_bytes      = PORT_BITS'(VW'(copy_reg));
    assign bytes_remaining = PORT_BITS'(VW'(tail_reg));

endmodule

// ===== rtl/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks on the allocator's request and result transfers.
// ----------------------------------------------------------------------------
module ffba_checker
    import ffba_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [2:0]           status,
    input logic                 result_valid,
    input logic                 moved
);

    // An accepted request makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request transfer did not raise busy");

    // The result strobe lasts one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // A valid result only comes with an ok status.
    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result_valid |-> status == ST_OK)
        else $error("valid result with error status");

    // A moved block always has a new start.
    a_moved_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done && moved |-> result_valid)
        else $error("move reported without a result");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .result_valid (result_valid),
    .moved        (moved)
);
